[src/bdq_pkg.sv]
package bdq_pkg;

   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;
   localparam int REQ_W    = 40;   // 35 payload bits, zero padded
   localparam int RSP_W    = 112;  // 105 payload bits, zero padded

   typedef enum logic [OP_W-1:0] {
      OP_ADD_FRONT  = 3'd0,
      OP_ADD_BACK   = 3'd1,
      OP_TAKE_FRONT = 3'd2,
      OP_TAKE_BACK  = 3'd3,
      OP_REMOVE     = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_PUSH,
      S_WALK,
      S_UNLINK,
      S_FRONT_FILL,
      S_BACK_FILL,
      S_DONE
   } state_type;

endpackage

[src/bdq_ram.sv]
module bdq_ram import bdq_pkg::*; #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

[src/bounded_deque_with_remove.sv]
// Channel  | Dir | Beat fields (tdata, lowest bit first)
// req_     | in  | operation[2:0], value[34:3], zero pad to 40 bits
// rsp_     | out | status[1:0], taken_value[33:2], entry_count[40:34],
//          |     | front_value[72:41], back_value[104:73], zero pad to 112
//
// An unused code or an error goes from decode straight to done.
// The remove walk reads one slot per cycle from the value/link memories.
// Reset clears control only; the free-slot memory uses a high-water mark,
// so no clearing pass is needed.
// One request in flight; a new beat is taken while a result waits in rsp_.
module bounded_deque_with_remove import bdq_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // operation, value
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // status, taken, count, front, back
);

   localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;

   logic [OP_W-1:0]    op_ff, op_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      hw_ff, hw_in;        // free memory valid below this
   logic [SW-1:0]      front_ff, front_in, back_ff, back_in;
   logic [SW-1:0]      cur_ff, cur_in, s_ff, s_in;
   logic [VALUE_W-1:0] fval_ff, fval_in, bval_ff, bval_in;
   logic [VALUE_W-1:0] taken_ff, taken_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   // memory ports
   logic [SW-1:0]      rd_addr;
   logic [VALUE_W-1:0] val_rd;
   logic [SW-1:0]      next_rd, prev_rd, free_rd;
   logic               val_we, next_we, prev_we, free_we;
   logic [SW-1:0]      val_wa, next_wa, prev_wa, free_wa;
   logic [SW-1:0]      next_wd, prev_wd, free_wd;
   logic [SW-1:0]      free_slot;

   logic is_push, is_pop, full, empty, out_free;

   assign is_push  = (op_ff == OP_ADD_FRONT) || (op_ff == OP_ADD_BACK);
   assign is_pop   = (op_ff == OP_TAKE_FRONT) || (op_ff == OP_TAKE_BACK) ||
                     (op_ff == OP_REMOVE);
   assign full     = (count_ff == CW'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign out_free = !rsp_valid_ff || rsp_tready;
   // never-written free entries hold their own index
   assign free_slot = (count_ff >= hw_ff) ? SW'(count_ff) : free_rd;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   bdq_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_val (
      .clock, .wr_en(val_we), .wr_addr(val_wa), .wr_data(val_ff),
      .rd_addr(rd_addr), .rd_data(val_rd));
   bdq_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next (
      .clock, .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(rd_addr), .rd_data(next_rd));
   bdq_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prev (
      .clock, .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_addr(rd_addr), .rd_data(prev_rd));
   bdq_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free (
      .clock, .wr_en(free_we), .wr_addr(free_wa), .wr_data(free_wd),
      .rd_addr(SW'(count_ff)), .rd_data(free_rd));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (is_push) begin
               state_in = full ? S_DONE : S_PUSH;
            end else if (!is_pop || empty) begin
               state_in = S_DONE;
            end else if (op_ff == OP_REMOVE && fval_ff != val_ff && bval_ff != val_ff) begin
               state_in = S_WALK;
            end else begin
               state_in = S_UNLINK;
            end
         end
         S_PUSH: state_in = S_DONE;
         S_WALK: begin
            if (val_rd == val_ff) state_in = S_UNLINK;
            else if (cur_ff == back_ff) state_in = S_DONE;
         end
         S_UNLINK: begin
            if (count_ff == CW'(1)) state_in = S_DONE;
            else if (s_ff == front_ff) state_in = S_FRONT_FILL;
            else if (s_ff == back_ff) state_in = S_BACK_FILL;
            else state_in = S_DONE;
         end
         S_FRONT_FILL, S_BACK_FILL: state_in = S_DONE;
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in = op_ff;   val_in = val_ff;   count_in = count_ff;  hw_in = hw_ff;
      front_in = front_ff;  back_in = back_ff;  cur_in = cur_ff;  s_in = s_ff;
      fval_in = fval_ff;  bval_in = bval_ff;  taken_in = taken_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rd_addr = cur_ff;
      val_we = 1'b0;  next_we = 1'b0;  prev_we = 1'b0;  free_we = 1'b0;
      val_wa = free_slot;  next_wa = '0;  prev_wa = '0;
      free_wa = SW'(count_ff - CW'(1));
      next_wd = '0;  prev_wd = '0;  free_wd = s_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in  = req_tdata[OP_W-1:0];
               val_in = req_tdata[OP_W +: VALUE_W];
            end
         end
         S_DECODE: begin
            taken_in  = '0;
            status_in = ST_OK;
            if (is_push) begin
               if (full) status_in = ST_FULL;
            end else if (is_pop) begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else if (op_ff == OP_TAKE_FRONT ||
                            (op_ff == OP_REMOVE && fval_ff == val_ff)) begin
                  s_in = front_ff;  rd_addr = front_ff;
               end else if (op_ff == OP_TAKE_BACK || bval_ff == val_ff) begin
                  s_in = back_ff;   rd_addr = back_ff;
               end else begin
                  cur_in = front_ff;  rd_addr = front_ff;
               end
            end
         end
         S_PUSH: begin
            val_we   = 1'b1;
            count_in = count_ff + CW'(1);
            if (count_ff >= hw_ff) hw_in = count_ff + CW'(1);
            if (empty) begin
               front_in = free_slot;  back_in = free_slot;
               fval_in  = val_ff;     bval_in = val_ff;
            end else if (op_ff == OP_ADD_FRONT) begin
               next_we = 1'b1;  next_wa = free_slot;  next_wd = front_ff;
               prev_we = 1'b1;  prev_wa = front_ff;   prev_wd = free_slot;
               front_in = free_slot;  fval_in = val_ff;
            end else begin
               prev_we = 1'b1;  prev_wa = free_slot;  prev_wd = back_ff;
               next_we = 1'b1;  next_wa = back_ff;    next_wd = free_slot;
               back_in = free_slot;  bval_in = val_ff;
            end
         end
         S_WALK: begin
            if (val_rd == val_ff) begin
               s_in = cur_ff;  rd_addr = cur_ff;
            end else if (cur_ff == back_ff) begin
               status_in = ST_NOT_FOUND;
            end else begin
               cur_in = next_rd;  rd_addr = next_rd;
            end
         end
         S_UNLINK: begin
            taken_in = val_rd;
            count_in = count_ff - CW'(1);
            free_we  = 1'b1;
            if (count_ff == CW'(1)) begin
               front_in = '0;  back_in = '0;
            end else if (s_ff == front_ff) begin
               front_in = next_rd;  rd_addr = next_rd;
            end else if (s_ff == back_ff) begin
               back_in = prev_rd;   rd_addr = prev_rd;
            end else begin
               next_we = 1'b1;  next_wa = prev_rd;  next_wd = next_rd;
               prev_we = 1'b1;  prev_wa = next_rd;  prev_wd = prev_rd;
            end
         end
         S_FRONT_FILL: fval_in = val_rd;
         S_BACK_FILL:  bval_in = val_rd;
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[104:0] = {empty ? '0 : bval_ff, empty ? '0 : fval_ff,
                                     COUNT_W'(count_ff), taken_ff, status_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         hw_ff        <= '0;
         front_ff     <= '0;
         back_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hw_ff        <= hw_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      val_ff      <= val_in;
      cur_ff      <= cur_in;
      s_ff        <= s_in;
      fval_ff     <= fval_in;
      bval_ff     <= bval_in;
      taken_ff    <= taken_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("entry count over capacity");

   a_hw_covers: assert property (@(posedge clock) disable iff (reset)
      count_ff <= hw_ff) else $error("count above free-stack mark");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && status_ff == ST_FULL) |-> full)
      else $error("full status with room left");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (rsp_tvalid && state_ff == S_IDLE))
      else $error("result not loaded");

endmodule
